>>> hdl/vslpf_pkg.sv
// Shared types and constants of the variable-step low-pass filter.
package vslpf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TIMER_W    = 16;
  localparam int ALPHA_FRAC = 16;
  localparam int STATE_FRAC = 16;
  localparam int STATE_W    = 32;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int DEN_W      = CFG_W + 1;
  localparam int QUOT_W     = ALPHA_FRAC + 1;
  localparam int NUM_W      = CFG_W + ALPHA_FRAC + 1;
  localparam int DIFF_W     = STATE_W + 1;
  localparam int PROD_W     = DIFF_W + QUOT_W + 1;
  localparam int COUNT_W    = $clog2(QUOT_W);
  localparam int IN_DATA_W  = SAMPLE_W + TIMER_W;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0] TIME_CONSTANT_RESET = 20'd50000;
  localparam logic [CFG_W-1:0] BYPASS_RESET        = 20'd300000;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONSTANT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_THRESHOLD = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_MULTIPLY,
    ST_ACCUMULATE,
    ST_DELIVER
  } state_t;

endpackage

>>> hdl/variable_step_lowpass_filter.sv
// Top level of the variable-step first-order low-pass filter.
//
// Channel   Direction  Handshake                Contents
// s_axis    in         s_tvalid / s_tready      tdata: sample, timer_count
// m_axis    out        m_tvalid / m_tready      tdata: filtered; tuser: bypassed
// cfg       in         cfg_we                   cfg_index, cfg_data
//
// A filtered request passes through setup, the 17 steps of the serial restoring divider
// that forms alpha, a multiply and an accumulate before it loads the output register.
// A bypassed request goes from setup straight to delivery.
// Input is accepted only while the sequencer is idle; a result waiting in the output
// register holds the next request in its last step, which keeps the input closed.
// Reset is synchronous and restores the default time constant and threshold.
module variable_step_lowpass_filter
  import vslpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // [15:0] sample, [31:16] timer_count
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // [15:0] filtered
  output logic                  m_tuser,  // [0] bypassed
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  state_t state, state_next;

  logic        [CFG_W-1:0]    time_constant;
  logic        [CFG_W-1:0]    bypass_threshold;
  logic signed [STATE_W-1:0]  previous_output;
  logic        [TIMER_W-1:0]  previous_timer;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic        [TIMER_W-1:0]  elapsed;
  logic        [DEN_W-1:0]    denom;
  logic        [DEN_W-1:0]    remainder;
  logic        [QUOT_W-1:0]   quotient;
  logic        [COUNT_W-1:0]  step_count;
  logic signed [PROD_W-1:0]   product;
  logic signed [STATE_W-1:0]  y_value;
  logic                       bypass_flag;

  logic        [SAMPLE_W-1:0] in_sample;
  logic        [TIMER_W-1:0]  in_timer;
  logic        [TIMER_W-1:0]  elapsed_in;
  logic                       in_accept;
  logic                       bypass_hit;
  logic        [DEN_W-1:0]    den_sum;
  logic        [NUM_W-1:0]    numerator;
  logic        [DEN_W:0]      trial;
  logic                       trial_fits;
  logic signed [STATE_W-1:0]  sample_scaled;
  logic signed [DIFF_W-1:0]   diff;
  logic        [QUOT_W-1:0]   alpha;
  logic signed [PROD_W-1:0]   prod_rounded;
  logic signed [STATE_W-1:0]  y_filtered;
  logic signed [STATE_W:0]    y_out_round;
  logic                       out_free;

  assign in_sample = s_tdata[SAMPLE_W-1:0];
  assign in_timer  = s_tdata[IN_DATA_W-1:SAMPLE_W];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign elapsed_in = (in_timer < previous_timer) ? (previous_timer - in_timer)
                                                  : ({TIMER_W{1'b1}} - in_timer + previous_timer);

  assign bypass_hit = {{(CFG_W-TIMER_W){1'b0}}, elapsed} > bypass_threshold;
  assign den_sum    = {1'b0, time_constant} + {{(DEN_W-TIMER_W){1'b0}}, elapsed};
  assign numerator  = {1'b0, time_constant, {ALPHA_FRAC{1'b0}}}
                    + {{(NUM_W-DEN_W+1){1'b0}}, den_sum[DEN_W-1:1]};

  assign trial      = {remainder, quotient[QUOT_W-1]};
  assign trial_fits = trial >= {1'b0, denom};

  assign sample_scaled = {sample_value, {STATE_FRAC{1'b0}}};
  assign diff  = {previous_output[STATE_W-1], previous_output}
               - {sample_scaled[STATE_W-1], sample_scaled};
  assign alpha = (denom == '0) ? '0 : quotient;

  assign prod_rounded = product + PROD_W'(1 << (ALPHA_FRAC - 1));
  assign y_filtered   = sample_scaled + STATE_W'(prod_rounded >>> ALPHA_FRAC);
  assign y_out_round  = {y_value[STATE_W-1], y_value} + (STATE_W+1)'(1 << (STATE_FRAC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = bypass_hit ? ST_DELIVER : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step_count == COUNT_W'(QUOT_W - 1)) begin
          state_next = ST_MULTIPLY;
        end
      end
      ST_MULTIPLY: begin
        state_next = ST_ACCUMULATE;
      end
      ST_ACCUMULATE: begin
        state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_constant    <= TIME_CONSTANT_RESET;
      bypass_threshold <= BYPASS_RESET;
      previous_output  <= '0;
      previous_timer   <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TIME_CONSTANT:    time_constant    <= cfg_data;
          CFG_BYPASS_THRESHOLD: bypass_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        previous_timer <= in_timer;
      end
      if (state == ST_SETUP && bypass_hit) begin
        previous_output <= sample_scaled;
      end
      if (state == ST_ACCUMULATE) begin
        previous_output <= y_filtered;
      end
      if (state == ST_DELIVER && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_value <= $signed(in_sample);
      elapsed      <= elapsed_in;
    end
    unique case (state)
      ST_SETUP: begin
        denom       <= den_sum;
        remainder   <= numerator[NUM_W-1:QUOT_W];
        quotient    <= numerator[QUOT_W-1:0];
        step_count  <= '0;
        y_value     <= sample_scaled;
        bypass_flag <= bypass_hit;
      end
      ST_DIVIDE: begin
        remainder  <= trial_fits ? DEN_W'(trial - {1'b0, denom}) : trial[DEN_W-1:0];
        quotient   <= {quotient[QUOT_W-2:0], trial_fits};
        step_count <= step_count + 1'b1;
      end
      ST_MULTIPLY: begin
        product <= diff * $signed({1'b0, alpha});
      end
      ST_ACCUMULATE: begin
        y_value <= y_filtered;
      end
      ST_DELIVER: begin
        if (out_free) begin
          m_tdata <= y_out_round[STATE_FRAC+OUT_DATA_W-1:STATE_FRAC];
          m_tuser <= bypass_flag;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/vslpf_checker.sv
// Port-level checks of the variable-step low-pass filter and their binding.
module vslpf_checker
  import vslpf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input accepted again while a request is in progress.");

  a_no_result_during_setup: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("Result appeared one cycle after a request was accepted.");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output valid right after reset.");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed or was dropped.");

endmodule

bind variable_step_lowpass_filter vslpf_checker u_vslpf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> bench/tb_variable_step_lowpass_filter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the variable-step low-pass filter, with a predictor of its output.
module tb_variable_step_lowpass_filter;
  import vslpf_pkg::*;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] filtered;
    logic                  bypassed;
  } lowpass_output_t;

  class lowpass_tracker;
    localparam longint ALPHA_ONE = longint'(1) << ALPHA_FRAC;
    localparam longint STATE_HALF = longint'(1) << (STATE_FRAC - 1);

    lowpass_output_t  expected_outputs[$];
    logic [CFG_W-1:0] time_constant;
    logic [CFG_W-1:0] bypass_threshold;
    longint           filter_state;
    logic [TIMER_W-1:0] last_timer;
    int               mismatches;

    function new();
      time_constant    = TIME_CONSTANT_RESET;
      bypass_threshold = BYPASS_RESET;
      filter_state     = 0;
      last_timer       = '0;
      mismatches       = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      case (index)
        CFG_TIME_CONSTANT: time_constant = value;
        CFG_BYPASS_THRESHOLD: bypass_threshold = value;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return expected_outputs.size();
    endfunction

    function void accept_sample(logic signed [SAMPLE_W-1:0] sample,
                                logic [TIMER_W-1:0] timer);
      longint          elapsed;
      longint          scaled_sample;
      longint          denominator;
      longint          alpha;
      longint          blend;
      lowpass_output_t prediction;
      scaled_sample = longint'(sample) * (longint'(1) << STATE_FRAC);
      if (timer < last_timer) begin
        elapsed = longint'(last_timer) - longint'(timer);
      end else begin
        elapsed = 65535 - longint'(timer) + longint'(last_timer);
      end
      last_timer = timer;
      if (elapsed > longint'(bypass_threshold)) begin
        filter_state        = scaled_sample;
        prediction.filtered = sample;
        prediction.bypassed = 1'b1;
      end else begin
        denominator = longint'(time_constant) + elapsed;
        alpha = 0;
        if (denominator != 0) begin
          alpha = ((longint'(time_constant) << ALPHA_FRAC) + denominator / 2) / denominator;
        end
        if (alpha > ALPHA_ONE) begin
          alpha = ALPHA_ONE;
        end
        blend = alpha * filter_state + (ALPHA_ONE - alpha) * scaled_sample + ALPHA_ONE / 2;
        filter_state = blend >>> ALPHA_FRAC;
        prediction.filtered = OUT_DATA_W'((filter_state + STATE_HALF) >>> STATE_FRAC);
        prediction.bypassed = 1'b0;
      end
      expected_outputs.push_back(prediction);
    endfunction

    function void check_output(logic [OUT_DATA_W-1:0] filtered, logic bypassed);
      lowpass_output_t oldest;
      if (expected_outputs.size() == 0) begin
        $error("unexpected output: filtered %0d, bypassed %0b", $signed(filtered), bypassed);
        mismatches++;
        return;
      end
      oldest = expected_outputs.pop_front();
      if (filtered !== oldest.filtered) begin
        $error("filtered: expected %0d, got %0d", $signed(oldest.filtered), $signed(filtered));
        mismatches++;
      end
      if (bypassed !== oldest.bypassed) begin
        $error("bypassed: expected %0b, got %0b", oldest.bypassed, bypassed);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  lowpass_tracker     tracker;
  bit                 steady_flow = 1'b0;
  int                 sink_hold_cycles = 0;
  logic [TIMER_W-1:0] timer_now = '0;
  logic signed [SAMPLE_W-1:0] sample_now = '0;

  variable_step_lowpass_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int next_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [TIMER_W-1:0] next_timer(logic [TIMER_W-1:0] current);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return current - TIMER_W'($urandom_range(1, 3000));
    if (pick < 80) return current - TIMER_W'($urandom_range(3000, 65535));
    if (pick < 88) return current;
    return TIMER_W'($urandom);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_sample(
      logic signed [SAMPLE_W-1:0] current);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return {1'b1, {(SAMPLE_W - 1){1'b0}}};
    if (pick < 12) return {1'b0, {(SAMPLE_W - 1){1'b1}}};
    if (pick < 30) return current;
    return SAMPLE_W'($urandom);
  endfunction

  initial begin : output_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        tracker.check_output(m_tdata, m_tuser);
      end
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        m_tready <= 1'b0;
      end else if (steady_flow) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        stall_left = next_gap();
        m_tready <= (stall_left == 0);
      end
    end
  end

  task automatic send_request(input logic signed [SAMPLE_W-1:0] sample,
                              input logic [TIMER_W-1:0] timer);
    int gap;
    gap = steady_flow ? 0 : next_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {timer, sample};
    do @(posedge clk); while (!s_tready);
    tracker.accept_sample(sample, timer);
  endtask

  task automatic wait_for_outputs();
    s_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    tracker.write_register(index, value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_filter(input logic [CFG_W-1:0] time_constant,
                            input logic [CFG_W-1:0] threshold);
    write_register(CFG_TIME_CONSTANT, time_constant);
    write_register(CFG_BYPASS_THRESHOLD, threshold);
  endtask

  initial begin : stimulus
    tracker = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a wrap from zero to all ones gives no elapsed time, equal
    // timer values give the longest step.
    send_request(16'sh7FFF, 16'hFFFF);
    send_request(16'sh8000, 16'hFFFF);
    send_request(16'sh7FFF, 16'h0000);
    send_request(16'sh8000, 16'h0001);
    send_request(16'sh0000, 16'h0000);
    send_request(-16'sd1, 16'h8000);
    send_request(16'sh7FFF, 16'h7FFF);
    wait_for_outputs();

    // A zero time constant makes the output follow the sample, even with no elapsed time.
    set_filter(20'd0, 20'hFFFFF);
    send_request(16'sd100, 16'h0000);
    send_request(16'sd200, 16'hFFFF);
    send_request(-16'sd300, 16'h8000);
    wait_for_outputs();

    // A zero threshold passes every sample that has any elapsed time.
    set_filter(20'hFFFFF, 20'd0);
    send_request(16'sd5, 16'h0000);
    send_request(16'sd7, 16'hFFFF);
    send_request(16'sh7FFF, 16'h1234);
    send_request(16'sh8000, 16'h1233);
    wait_for_outputs();

    set_filter(20'hFFFFF, 20'd65534);
    send_request(16'sd1234, 16'h1233);
    send_request(-16'sd1234, 16'h1000);
    wait_for_outputs();
    timer_now = 16'h1000;
    sample_now = -16'sd1234;

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_filter(TIME_CONSTANT_RESET, BYPASS_RESET);
        1: set_filter(CFG_W'($urandom_range(1, 2000)), CFG_W'($urandom_range(0, 5000)));
        2: set_filter(20'hFFFFF, 20'hFFFFF);
        3: set_filter(CFG_W'($urandom_range(1, 1048575)), 20'd65534);
        4: set_filter(20'd1, CFG_W'($urandom_range(30000, 70000)));
        default: set_filter(CFG_W'($urandom_range(100, 100000)),
                            CFG_W'($urandom_range(0, 65535)));
      endcase
      steady_flow = (phase == 2);
      if (phase == 3) begin
        sink_hold_cycles = 400;
      end
      for (int n = 0; n < 100; n++) begin
        sample_now = next_sample(sample_now);
        timer_now  = next_timer(timer_now);
        send_request(sample_now, timer_now);
        if (n == 50) begin
          wait_for_outputs();
        end
      end
      wait_for_outputs();
    end
    steady_flow = 1'b0;

    repeat (30) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/vslpf_pkg.sv
hdl/variable_step_lowpass_filter.sv
hdl/vslpf_checker.sv
bench/tb_variable_step_lowpass_filter.sv
